>>> rtl/core/pir_dli_pkg.sv
// shared types, constants and helpers of the pir direct link interface
`default_nettype none
package pir_dli_pkg;

   localparam int CFG_BITS  = 25;
   localparam int VAL_BITS  = 15;
   localparam int WORD_BITS = CFG_BITS + VAL_BITS;
   localparam int TMR_BITS  = 12;
   localparam int CNT_BITS  = 6;
   localparam int IDX_BITS  = 3;

   // commands carried by a request
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // register indexes
   localparam logic [IDX_BITS-1:0] REG_WR_BIT_HOLD   = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_WR_LATCH      = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_LINK_RST_LOW  = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_RD_SETUP_HIGH = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_RD_BIT_SETTLE = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_RD_END_LOW    = 3'd5;

   // register reset values
   localparam logic [TMR_BITS-1:0] RST_WR_BIT_HOLD   = 12'd100;
   localparam logic [TMR_BITS-1:0] RST_WR_LATCH      = 12'd700;
   localparam logic [TMR_BITS-1:0] RST_LINK_RST_LOW  = 12'd200;
   localparam logic [TMR_BITS-1:0] RST_RD_SETUP_HIGH = 12'd130;
   localparam logic [TMR_BITS-1:0] RST_RD_BIT_SETTLE = 12'd15;
   localparam logic [TMR_BITS-1:0] RST_RD_END_LOW    = 12'd1300;

   // fixed phase lengths
   localparam logic [TMR_BITS-1:0] WR_PRE_TICKS = 12'd2;
   localparam logic [TMR_BITS-1:0] ONE_TICK     = 12'd1;

   // readout field masks
   localparam logic [VAL_BITS-1:0] VAL_RANGE_BIT = 15'h4000;
   localparam logic [VAL_BITS-1:0] VAL_DATA_MASK = 15'h3FFF;
   localparam logic [VAL_BITS-1:0] VAL_SIGN_BIT  = 15'h2000;
   localparam logic [CFG_BITS-1:0] ST_MODE_MASK  = 25'h60;
   localparam logic [CFG_BITS-1:0] ST_TOP_BIT    = 25'h1000000;

   typedef enum logic [12:0] {
      PH_IDLE      = 13'b0000000000001,
      PH_WR_PRE    = 13'b0000000000010,
      PH_WR_LO     = 13'b0000000000100,
      PH_WR_HI     = 13'b0000000001000,
      PH_WR_HOLD   = 13'b0000000010000,
      PH_WR_LATCH  = 13'b0000000100000,
      PH_RD_RST    = 13'b0000001000000,
      PH_RD_SETUP  = 13'b0000010000000,
      PH_RD_LO     = 13'b0000100000000,
      PH_RD_HI     = 13'b0001000000000,
      PH_RD_SETTLE = 13'b0010000000000,
      PH_RD_END    = 13'b0100000000000,
      PH_CLR       = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic [VAL_BITS-1:0] value;
      logic [CFG_BITS-1:0] status;
      logic                range;
   } result_type;

   // a zero length counts as one tick; timer holds ticks left minus one
   function automatic logic [TMR_BITS-1:0] timer_load(input logic [TMR_BITS-1:0] len);
      timer_load = (len == '0) ? '0 : len - ONE_TICK;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/pir_direct_link_interface_unit.sv
// top level of the pir sensor serial-in and direct link pin controller
// usage:
//  - one request stands for one microsecond tick: a command (tick, write,
//    read, clear), a 25-bit config word and the sampled link level
//  - every request yields exactly one response with the serial-in level, the
//    link drive enable and level, busy, read done and the last read result
//  - the response of a request is registered: it sits in the response
//    register from the edge after its acceptance
//  - throughput is one request per cycle if not stalled; the response register
//    decouples the sides, req_ready is high when it is empty or being drained
//  - a stalled response (rsp_ready low) holds the register and, once it is
//    full, stops requests; no tick is lost or repeated
//  - commands are taken only while idle; commands during a sequence are
//    ignored but still tick the sequence
//  - reset (synchronous, active high) returns to idle with the link released,
//    serial-in low, results cleared and timing registers at their defaults
//  - timing registers are written through csr_ with no wait; write them only
//    while idle
`default_nettype none
module pir_direct_link_interface_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_op,
   input  wire logic [pir_dli_pkg::CFG_BITS-1:0]    req_config_word,
   input  wire logic                                req_link_level,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_serin_level,
   output logic                                     rsp_link_drive_enable,
   output logic                                     rsp_link_drive_level,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_read_done,
   output logic signed [pir_dli_pkg::VAL_BITS-1:0]  rsp_sample_value,
   output logic [pir_dli_pkg::CFG_BITS-1:0]         rsp_status_config,
   output logic                                     rsp_out_of_range,
   // register write port
   input  wire logic                                csr_write_enable,
   input  wire logic [pir_dli_pkg::IDX_BITS-1:0]    csr_index,
   input  wire logic [pir_dli_pkg::TMR_BITS-1:0]    csr_write_data
);

   localparam int TB = pir_dli_pkg::TMR_BITS;
   localparam int CB = pir_dli_pkg::CNT_BITS;
   localparam int WB = pir_dli_pkg::WORD_BITS;

   // timing registers
   logic [TB-1:0] wr_bit_hold_ff, wr_latch_ff, link_rst_low_ff;
   logic [TB-1:0] rd_setup_high_ff, rd_bit_settle_ff, rd_end_low_ff;

   // sequencer state
   pir_dli_pkg::phase_type phase_ff, phase_in;
   logic [TB-1:0]          timer_ff, timer_in;
   logic [CB-1:0]          bitcnt_ff, bitcnt_in, bitcnt_inc;
   logic [WB-1:0]          shift_ff, shift_in;
   logic                   wakeup_ff, wakeup_in;

   // response register; serin and the result fields double as held state
   logic                                  rsp_valid_ff;
   logic                                  serin_ff, serin_in;
   logic                                  link_en_ff, link_en_in;
   logic                                  link_lvl_ff, link_lvl_in;
   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [pir_dli_pkg::VAL_BITS-1:0]      value_ff, value_in;
   logic [pir_dli_pkg::CFG_BITS-1:0]      status_ff, status_in;
   logic                                  range_ff, range_in;

   logic                                  accept;
   logic [4:0]                            wr_bit_idx;
   logic [pir_dli_pkg::CFG_BITS-1:0]      wr_word;
   pir_dli_pkg::result_type               fixed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // result correction works on the captured word, stable during end-low
   pir_dli_readout_fix u_fix (
      .word   (shift_ff),
      .wakeup (wakeup_ff),
      .res    (fixed)
   );

   assign wr_word    = shift_ff[pir_dli_pkg::CFG_BITS-1:0];
   assign wr_bit_idx = 5'(pir_dli_pkg::CFG_BITS - 1) - bitcnt_ff[4:0];
   assign bitcnt_inc = bitcnt_ff + 1'b1;

   // one tick of the sequencer
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      wakeup_in = wakeup_ff;
      serin_in  = serin_ff;
      done_in   = 1'b0;
      value_in  = value_ff;
      status_in = status_ff;
      range_in  = range_ff;

      // command intake, idle only
      if (phase_ff == pir_dli_pkg::PH_IDLE) begin
         case (req_op)
            pir_dli_pkg::OP_WRITE: begin
               shift_in  = {{pir_dli_pkg::VAL_BITS{1'b0}}, req_config_word};
               bitcnt_in = '0;
               phase_in  = pir_dli_pkg::PH_WR_PRE;
               timer_in  = pir_dli_pkg::timer_load(pir_dli_pkg::WR_PRE_TICKS);
            end
            pir_dli_pkg::OP_READ: begin
               wakeup_in = req_link_level;
               shift_in  = '0;
               bitcnt_in = '0;
               phase_in  = pir_dli_pkg::PH_RD_RST;
               timer_in  = pir_dli_pkg::timer_load(link_rst_low_ff);
            end
            pir_dli_pkg::OP_CLEAR: begin
               phase_in = pir_dli_pkg::PH_CLR;
               timer_in = pir_dli_pkg::timer_load(link_rst_low_ff);
            end
            default: begin
            end
         endcase
      end

      // pin levels for this tick
      case (phase_in)
         pir_dli_pkg::PH_WR_PRE, pir_dli_pkg::PH_WR_LO, pir_dli_pkg::PH_WR_LATCH: begin
            serin_in    = 1'b0;
            link_en_in  = 1'b1;
            link_lvl_in = 1'b0;
         end
         pir_dli_pkg::PH_WR_HI: begin
            serin_in    = 1'b1;
            link_en_in  = 1'b1;
            link_lvl_in = 1'b0;
         end
         pir_dli_pkg::PH_WR_HOLD: begin
            serin_in    = (bitcnt_ff < CB'(pir_dli_pkg::CFG_BITS)) ? wr_word[wr_bit_idx] : 1'b0;
            link_en_in  = 1'b1;
            link_lvl_in = 1'b0;
         end
         pir_dli_pkg::PH_RD_RST, pir_dli_pkg::PH_RD_LO, pir_dli_pkg::PH_RD_END,
         pir_dli_pkg::PH_CLR: begin
            link_en_in  = 1'b1;
            link_lvl_in = 1'b0;
         end
         pir_dli_pkg::PH_RD_SETUP, pir_dli_pkg::PH_RD_HI: begin
            link_en_in  = 1'b1;
            link_lvl_in = 1'b1;
         end
         default: begin
            link_en_in  = 1'b0;
            link_lvl_in = 1'b0;
         end
      endcase
      busy_in = (phase_in != pir_dli_pkg::PH_IDLE);

      // advance the phase timer and sequence
      if (phase_in != pir_dli_pkg::PH_IDLE) begin
         if (timer_in != '0) begin
            timer_in = timer_in - 1'b1;
         end else begin
            case (phase_in)
               pir_dli_pkg::PH_WR_PRE, pir_dli_pkg::PH_WR_HOLD: begin
                  if (phase_in == pir_dli_pkg::PH_WR_HOLD) begin
                     bitcnt_in = bitcnt_inc;
                  end
                  if (bitcnt_in >= CB'(pir_dli_pkg::CFG_BITS)) begin
                     phase_in = pir_dli_pkg::PH_WR_LATCH;
                     timer_in = pir_dli_pkg::timer_load(wr_latch_ff);
                  end else begin
                     phase_in = pir_dli_pkg::PH_WR_LO;
                     timer_in = '0;
                  end
               end
               pir_dli_pkg::PH_WR_LO: begin
                  phase_in = pir_dli_pkg::PH_WR_HI;
                  timer_in = '0;
               end
               pir_dli_pkg::PH_WR_HI: begin
                  phase_in = pir_dli_pkg::PH_WR_HOLD;
                  timer_in = pir_dli_pkg::timer_load(wr_bit_hold_ff);
               end
               pir_dli_pkg::PH_RD_RST: begin
                  phase_in = pir_dli_pkg::PH_RD_SETUP;
                  timer_in = pir_dli_pkg::timer_load(rd_setup_high_ff);
               end
               pir_dli_pkg::PH_RD_SETUP: begin
                  phase_in = pir_dli_pkg::PH_RD_LO;
                  timer_in = '0;
               end
               pir_dli_pkg::PH_RD_LO: begin
                  phase_in = pir_dli_pkg::PH_RD_HI;
                  timer_in = '0;
               end
               pir_dli_pkg::PH_RD_HI: begin
                  phase_in = pir_dli_pkg::PH_RD_SETTLE;
                  timer_in = pir_dli_pkg::timer_load(rd_bit_settle_ff);
               end
               pir_dli_pkg::PH_RD_SETTLE: begin
                  // sample the link, msb first
                  shift_in  = {shift_ff[WB-2:0], req_link_level};
                  bitcnt_in = bitcnt_inc;
                  if (bitcnt_inc >= CB'(WB)) begin
                     phase_in = pir_dli_pkg::PH_RD_END;
                     timer_in = pir_dli_pkg::timer_load(rd_end_low_ff);
                  end else begin
                     phase_in = pir_dli_pkg::PH_RD_LO;
                     timer_in = '0;
                  end
               end
               pir_dli_pkg::PH_RD_END: begin
                  value_in  = fixed.value;
                  status_in = fixed.status;
                  range_in  = fixed.range;
                  done_in   = 1'b1;
                  phase_in  = pir_dli_pkg::PH_IDLE;
                  timer_in  = '0;
               end
               default: begin
                  phase_in = pir_dli_pkg::PH_IDLE;
                  timer_in = '0;
               end
            endcase
         end
      end
   end

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_bit_hold_ff   <= pir_dli_pkg::RST_WR_BIT_HOLD;
         wr_latch_ff      <= pir_dli_pkg::RST_WR_LATCH;
         link_rst_low_ff  <= pir_dli_pkg::RST_LINK_RST_LOW;
         rd_setup_high_ff <= pir_dli_pkg::RST_RD_SETUP_HIGH;
         rd_bit_settle_ff <= pir_dli_pkg::RST_RD_BIT_SETTLE;
         rd_end_low_ff    <= pir_dli_pkg::RST_RD_END_LOW;
      end else if (csr_write_enable) begin
         case (csr_index)
            pir_dli_pkg::REG_WR_BIT_HOLD:   wr_bit_hold_ff   <= csr_write_data;
            pir_dli_pkg::REG_WR_LATCH:      wr_latch_ff      <= csr_write_data;
            pir_dli_pkg::REG_LINK_RST_LOW:  link_rst_low_ff  <= csr_write_data;
            pir_dli_pkg::REG_RD_SETUP_HIGH: rd_setup_high_ff <= csr_write_data;
            pir_dli_pkg::REG_RD_BIT_SETTLE: rd_bit_settle_ff <= csr_write_data;
            pir_dli_pkg::REG_RD_END_LOW:    rd_end_low_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // sequencer and response register, stepped once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= pir_dli_pkg::PH_IDLE;
         timer_ff     <= '0;
         bitcnt_ff    <= '0;
         shift_ff     <= '0;
         wakeup_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         serin_ff     <= 1'b0;
         link_en_ff   <= 1'b0;
         link_lvl_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         value_ff     <= '0;
         status_ff    <= '0;
         range_ff     <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            bitcnt_ff    <= bitcnt_in;
            shift_ff     <= shift_in;
            wakeup_ff    <= wakeup_in;
            rsp_valid_ff <= 1'b1;
            serin_ff     <= serin_in;
            link_en_ff   <= link_en_in;
            link_lvl_ff  <= link_lvl_in;
            busy_ff      <= busy_in;
            done_ff      <= done_in;
            value_ff     <= value_in;
            status_ff    <= status_in;
            range_ff     <= range_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_serin_level       = serin_ff;
   assign rsp_link_drive_enable = link_en_ff;
   assign rsp_link_drive_level  = link_lvl_ff;
   assign rsp_busy_res          = busy_ff;
   assign rsp_read_done         = done_ff;
   assign rsp_sample_value      = value_ff;
   assign rsp_status_config     = status_ff;
   assign rsp_out_of_range      = range_ff;

   // a read completes only inside a busy tick
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> busy_ff)
      else $error("read done outside a busy tick");

   // a plain tick taken while idle reports not busy
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == pir_dli_pkg::PH_IDLE) && (req_op == pir_dli_pkg::OP_TICK)
      |=> !busy_ff && !link_en_ff)
      else $error("idle tick reported busy or driving");

   // the bit counter never runs past one readout frame
   a_bitcnt_range: assert property (@(posedge clock) disable iff (reset)
      bitcnt_ff <= CB'(WB))
      else $error("bit counter out of range");

   // released link never carries a driven level
   a_link_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !link_en_ff |-> !link_lvl_ff)
      else $error("link level set while released");

endmodule
`default_nettype wire

>>> rtl/core/pir_dli_readout_fix.sv
// correction of a 40-bit readout into value, status and range flag
`default_nettype none
module pir_dli_readout_fix (
   input  wire logic [pir_dli_pkg::WORD_BITS-1:0] word,
   input  wire logic                              wakeup,
   output pir_dli_pkg::result_type                res
);

   logic [pir_dli_pkg::VAL_BITS-1:0] raw_val;
   logic [pir_dli_pkg::CFG_BITS-1:0] raw_st;
   logic [pir_dli_pkg::VAL_BITS-1:0] val;
   logic [pir_dli_pkg::CFG_BITS-1:0] st;
   logic                             oor;

   always_comb begin
      raw_val = word[pir_dli_pkg::WORD_BITS-1:pir_dli_pkg::CFG_BITS];
      raw_st  = word[pir_dli_pkg::CFG_BITS-1:0];
      oor     = ((raw_val & pir_dli_pkg::VAL_RANGE_BIT) == '0);
      val     = raw_val;
      st      = raw_st;
      // wake-up mode: everything arrives one bit late
      if (wakeup) begin
         val = raw_val >> 1;
         st  = (raw_st >> 1) | (raw_val[0] ? pir_dli_pkg::ST_TOP_BIT : '0);
         oor = 1'b0;
      end
      val = val & pir_dli_pkg::VAL_DATA_MASK;
      if (((st & pir_dli_pkg::ST_MODE_MASK) == '0) &&
          ((val & pir_dli_pkg::VAL_SIGN_BIT) != '0)) begin
         val = val | pir_dli_pkg::VAL_RANGE_BIT;
      end
      res.value  = val;
      res.status = st;
      res.range  = oor;
   end

endmodule
`default_nettype wire
